// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the interpolator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define H2P_ASSERT(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("Interpolator assertion failed.");

// Concurrent check that also runs during reset.
`define H2P_ASSERT_RESET(label, clock, prop) \
  label: assert property (@(posedge clock) prop) \
    else $error("Interpolator reset assertion failed.");

`endif

// ----- hdl/h2p_pkg.sv -----
// Package with the calibration table, widths and pipeline stage numbers of the interpolator.
`timescale 1ns / 1ps

package h2p_pkg;

  localparam int TABLE_POINTS = 14;
  localparam int SEG_COUNT    = TABLE_POINTS - 1;
  localparam int IDX_W        = (SEG_COUNT > 1) ? $clog2(SEG_COUNT) : 1;
  localparam int FRAC_BITS    = 16;
  localparam int HEIGHT_W     = 10;
  localparam int LEVEL_W      = 8;
  localparam int RAW_W        = 13;
  localparam int BASE_W       = 11;
  localparam int FRAC_W       = FRAC_BITS + 2;
  localparam int DIFF_W       = RAW_W + 2;

  localparam int IN_TDATA_W   = ((RAW_W + FRAC_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((LEVEL_W + 7) / 8) * 8;

  localparam logic [HEIGHT_W-1:0] CAL_HEIGHT [TABLE_POINTS] = '{
    10'd144, 10'd224, 10'd320, 10'd400, 10'd448, 10'd480, 10'd504,
    10'd520, 10'd528, 10'd536, 10'd552, 10'd560, 10'd568, 10'd576
  };

  localparam logic [LEVEL_W-1:0] CAL_LEVEL [TABLE_POINTS] = '{
    8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70,
    8'd80, 8'd90, 8'd100, 8'd110, 8'd120, 8'd130, 8'd140
  };

  localparam int TABLE_SPAN = int'(CAL_HEIGHT[TABLE_POINTS-1]) - int'(CAL_HEIGHT[0]);
  localparam int SPAN_W     = $clog2(TABLE_SPAN + 1);
  localparam int ONE        = 1 << FRAC_BITS;

  // Raw height to fraction: reciprocal of the span with one correction step.
  localparam int NUM_RAW_W  = SPAN_W + FRAC_BITS;
  localparam int RCP_RAW_W  = FRAC_BITS + 2;
  localparam longint unsigned RCP_RAW = (64'd1 << NUM_RAW_W) / TABLE_SPAN;

  // Segment interpolation: numerator and per-segment reciprocal widths.
  localparam int NUM_W      = LEVEL_W + FRAC_BITS;
  localparam int SEG_W_W    = FRAC_BITS + 1;
  localparam int RCP_SEG_W  = NUM_W + 1;

  localparam int STAGES     = 8;
  localparam int STG_DIFF   = 0;
  localparam int STG_EST    = 1;
  localparam int STG_FRAC   = 2;
  localparam int STG_SEG    = 3;
  localparam int STG_NUM    = 4;
  localparam int STG_RCP    = 5;
  localparam int STG_FIX    = 6;
  localparam int STG_OUT    = 7;

  typedef struct packed {
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] valid;
  } pipe_ctrl_t;

  function automatic logic [FRAC_BITS:0] cal_break(input int i);
    longint unsigned num;
    num = (longint'(CAL_HEIGHT[i]) - longint'(CAL_HEIGHT[0])) << FRAC_BITS;
    return (FRAC_BITS + 1)'(num / TABLE_SPAN);
  endfunction

endpackage

// ----- hdl/h2p_interp.sv -----
// Segment search and linear interpolation stages of the interpolator.
`timescale 1ns / 1ps

module h2p_interp import h2p_pkg::*; (
  input  logic                      clk,
  input  pipe_ctrl_t                ctrl,
  input  logic signed [FRAC_W-1:0]  frac_in,
  output logic [LEVEL_W-1:0]        level
);

  logic [FRAC_BITS:0]   brk_lo  [SEG_COUNT];
  logic [SEG_W_W-1:0]   seg_w   [SEG_COUNT];
  logic [RCP_SEG_W-1:0] seg_rcp [SEG_COUNT];
  logic [LEVEL_W-1:0]   seg_dl  [SEG_COUNT];

  for (genvar g = 0; g < SEG_COUNT; g++) begin : g_seg
    localparam logic [FRAC_BITS:0] LO   = cal_break(g);
    localparam logic [FRAC_BITS:0] HI   = cal_break(g + 1);
    localparam logic [FRAC_BITS:0] WID  = HI - LO;
    localparam longint unsigned    RCP  = (64'd1 << NUM_W) / WID;
    assign brk_lo[g]  = LO;
    assign seg_w[g]   = SEG_W_W'(WID);
    assign seg_rcp[g] = RCP_SEG_W'(RCP);
    assign seg_dl[g]  = CAL_LEVEL[g + 1] - CAL_LEVEL[g];
  end

  logic                 ld_seg, ld_num, ld_rcp, ld_fix, ld_out;
  logic [IDX_W-1:0]     seg_idx;
  logic                 frac_top, frac_low;

  logic [IDX_W-1:0]     idx3, idx4, idx5, idx6;
  logic [FRAC_BITS-1:0] uf3;
  logic                 top3, low3, top4, low4, top5, low5, top6, low6;
  logic [NUM_W-1:0]     num4, num5;
  logic [LEVEL_W-1:0]   qest5, q6;

  logic [FRAC_BITS-1:0]         seg_off;
  logic [NUM_W+RCP_SEG_W-1:0]   seg_prod;
  logic [NUM_W-1:0]             seg_rem;

  assign ld_seg = ctrl.load[STG_SEG] && ctrl.valid[STG_SEG];
  assign ld_num = ctrl.load[STG_NUM] && ctrl.valid[STG_NUM];
  assign ld_rcp = ctrl.load[STG_RCP] && ctrl.valid[STG_RCP];
  assign ld_fix = ctrl.load[STG_FIX] && ctrl.valid[STG_FIX];
  assign ld_out = ctrl.load[STG_OUT] && ctrl.valid[STG_OUT];

  always_comb begin
    seg_idx = '0;
    for (int i = 1; i < SEG_COUNT; i++) begin
      if (frac_in >= $signed({1'b0, brk_lo[i]})) begin
        seg_idx = IDX_W'(i);
      end
    end
  end

  assign frac_top = frac_in >= $signed(FRAC_W'(ONE));
  assign frac_low = frac_in[FRAC_W-1] || (frac_in == '0);

  assign seg_off  = uf3 - brk_lo[idx3][FRAC_BITS-1:0];
  assign seg_prod = (NUM_W + RCP_SEG_W)'(num4) * (NUM_W + RCP_SEG_W)'(seg_rcp[idx4]);
  assign seg_rem  = num5 - NUM_W'(NUM_W'(qest5) * NUM_W'(seg_w[idx5]));

  always_ff @(posedge clk) begin
    if (ld_seg) begin
      idx3 <= seg_idx;
      uf3  <= frac_in[FRAC_BITS-1:0];
      top3 <= frac_top;
      low3 <= frac_low;
    end
    if (ld_num) begin
      num4 <= NUM_W'(seg_dl[idx3]) * NUM_W'(seg_off);
      idx4 <= idx3;
      top4 <= top3;
      low4 <= low3;
    end
    if (ld_rcp) begin
      qest5 <= seg_prod[NUM_W +: LEVEL_W];
      num5  <= num4;
      idx5  <= idx4;
      top5  <= top4;
      low5  <= low4;
    end
    if (ld_fix) begin
      q6   <= qest5 + LEVEL_W'(seg_rem >= NUM_W'(seg_w[idx5]));
      idx6 <= idx5;
      top6 <= top5;
      low6 <= low5;
    end
    if (ld_out) begin
      if (top6) begin
        level <= CAL_LEVEL[TABLE_POINTS-1];
      end else if (low6) begin
        level <= CAL_LEVEL[0];
      end else begin
        level <= CAL_LEVEL[idx6] + q6;
      end
    end
  end

endmodule

// ----- hdl/height_to_pwm_interpolator_core.sv -----
// Top level of the height to pump drive level interpolator.
//
//   Channel  Direction  Payload
//   s_*      in         tuser: action; tdata: height_raw, height_scaled
//   m_*      out        tdata: pump_level
//   cfg_*    in         base_height, written when cfg_wen is high
//
// Each item passes eight register stages. One item is taken every cycle while the
// pipeline is not held by an output stall.
// The two constant-reciprocal multiplications and their corrections set the depth.
// A stall only holds the stages that are full; empty stages keep filling.
// Reset clears the stage valid bits and base_height.
`timescale 1ns / 1ps

module height_to_pwm_interpolator_core import h2p_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_TDATA_W-1:0]   s_tdata,  // height_raw, height_scaled, zero fill
  input  logic                    s_tuser,  // action
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_TDATA_W-1:0]  m_tdata,  // pump_level
  input  logic                    cfg_wen,
  input  logic [BASE_W-1:0]       cfg_wdata
);

  logic signed [BASE_W-1:0] base_height;
  logic [STAGES-1:0]        valid;
  logic [STAGES:0]          ready_chain;
  pipe_ctrl_t               ctrl;

  logic signed [RAW_W-1:0]  in_raw;
  logic signed [FRAC_W-1:0] in_scaled;

  logic signed [DIFF_W-1:0] diff0;
  logic                     act0;
  logic signed [FRAC_W-1:0] scaled0;

  logic [SPAN_W-1:0]        dlow1;
  logic [FRAC_BITS-1:0]     qest1;
  logic                     lo1, hi1, act1;
  logic signed [FRAC_W-1:0] scaled1;

  logic signed [FRAC_W-1:0] frac2;

  logic [NUM_RAW_W-1:0]           raw_num;
  logic [NUM_RAW_W+RCP_RAW_W-1:0] raw_prod;
  logic [NUM_RAW_W-1:0]           raw_rem;
  logic [FRAC_BITS-1:0]           raw_q;
  logic                           diff_low, diff_high;
  logic [LEVEL_W-1:0]             level;

  assign in_raw    = s_tdata[RAW_W-1:0];
  assign in_scaled = s_tdata[RAW_W +: FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_height <= '0;
    end else if (cfg_wen) begin
      base_height <= cfg_wdata;
    end
  end

  always_comb begin
    ready_chain[STAGES] = m_tready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      ready_chain[k] = !valid[k] || ready_chain[k + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready_chain[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (ready_chain[k]) begin
          valid[k] <= valid[k - 1];
        end
      end
    end
  end

  assign ctrl.load  = ready_chain[STAGES-1:0];
  assign ctrl.valid = {valid[STAGES-2:0], s_tvalid};
  assign s_tready   = ready_chain[0];
  assign m_tvalid   = valid[STAGES-1];

  assign diff_low  = diff0[DIFF_W-1] || (diff0 == '0);
  assign diff_high = !diff0[DIFF_W-1] && (diff0 >= DIFF_W'(TABLE_SPAN));
  assign raw_num   = {diff0[SPAN_W-1:0], {FRAC_BITS{1'b0}}};
  assign raw_prod  = (NUM_RAW_W + RCP_RAW_W)'(raw_num) * (NUM_RAW_W + RCP_RAW_W)'(RCP_RAW);
  assign raw_rem   = {dlow1, {FRAC_BITS{1'b0}}}
                     - NUM_RAW_W'(NUM_RAW_W'(qest1) * NUM_RAW_W'(TABLE_SPAN));
  assign raw_q     = qest1 + FRAC_BITS'(raw_rem >= NUM_RAW_W'(TABLE_SPAN));

  always_ff @(posedge clk) begin
    if (ctrl.load[STG_DIFF] && ctrl.valid[STG_DIFF]) begin
      diff0   <= DIFF_W'(in_raw) + DIFF_W'(base_height) - DIFF_W'(CAL_HEIGHT[0]);
      act0    <= s_tuser;
      scaled0 <= in_scaled;
    end
    if (ctrl.load[STG_EST] && ctrl.valid[STG_EST]) begin
      dlow1   <= diff0[SPAN_W-1:0];
      qest1   <= raw_prod[NUM_RAW_W +: FRAC_BITS];
      lo1     <= diff_low;
      hi1     <= diff_high;
      act1    <= act0;
      scaled1 <= scaled0;
    end
    if (ctrl.load[STG_FRAC] && ctrl.valid[STG_FRAC]) begin
      if (act1) begin
        frac2 <= scaled1;
      end else if (lo1) begin
        frac2 <= '0;
      end else if (hi1) begin
        frac2 <= FRAC_W'(ONE);
      end else begin
        frac2 <= FRAC_W'(raw_q);
      end
    end
  end

  h2p_interp u_interp (
    .clk     (clk),
    .ctrl    (ctrl),
    .frac_in (frac2),
    .level   (level)
  );

  assign m_tdata = OUT_TDATA_W'(level);

endmodule

// ----- hdl/h2p_checker.sv -----
// Port-level checker for the interpolator and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module h2p_checker import h2p_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  `H2P_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `H2P_ASSERT(a_out_range, clk, rst, m_tvalid |-> (m_tdata >= OUT_TDATA_W'(CAL_LEVEL[0])) && (m_tdata <= OUT_TDATA_W'(CAL_LEVEL[TABLE_POINTS-1])))
  `H2P_ASSERT(a_ready_when_drained, clk, rst, !m_tvalid |-> s_tready)
  `H2P_ASSERT_RESET(a_reset_empties, clk, rst |=> !m_tvalid)

endmodule

bind height_to_pwm_interpolator_core h2p_checker u_h2p_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- sim/tb_height_to_pwm_interpolator_core.sv -----
// Self-checking testbench for the height to pump drive level interpolator.
`timescale 1ns / 1ps

module tb_height_to_pwm_interpolator_core;
  import h2p_pkg::*;

  localparam int  POINTS      = 14;
  localparam int  FRAC_SHIFT  = 16;
  localparam longint UNITY    = longint'(1) << FRAC_SHIFT;
  localparam longint SPAN     = 432;
  localparam int  HOLD_CYCLES = 300;
  localparam int  CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic               action;
    logic signed [12:0] raw;
    logic signed [17:0] frac;
  } height_req_t;

  int point_height [POINTS] = '{144, 224, 320, 400, 448, 480, 504,
                                520, 528, 536, 552, 560, 568, 576};
  int point_level [POINTS] = '{10, 20, 30, 40, 50, 60, 70,
                               80, 90, 100, 110, 120, 130, 140};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_wen = 1'b0;
  logic [BASE_W-1:0]      cfg_wdata = '0;

  height_req_t       height_requests [$];
  logic [7:0]        expected_levels [$];
  height_req_t       next_req;
  logic [7:0]        level_due;
  logic signed [10:0] base_cfg = '0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int failures      = 0;
  int cycle_count   = 0;

  height_to_pwm_interpolator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint seg_break(input int k);
    return ((longint'(point_height[k]) - point_height[0]) << FRAC_SHIFT) / SPAN;
  endfunction

  function automatic logic [7:0] drive_level(input logic action,
                                             input logic signed [12:0] raw,
                                             input logic signed [17:0] frac,
                                             input logic signed [10:0] base);
    longint d;
    longint f;
    longint lo;
    longint hi;
    longint level;
    if (!action) begin
      d = longint'(raw) + longint'(base) - point_height[0];
      if (d <= 0) begin
        f = 0;
      end else if (d >= SPAN) begin
        f = UNITY;
      end else begin
        f = (d << FRAC_SHIFT) / SPAN;
      end
    end else begin
      f = longint'(frac);
    end
    level = point_level[POINTS-1];
    if (f <= 0) begin
      level = point_level[0];
    end else if (f < UNITY) begin
      for (int i = 0; i < POINTS - 1; i++) begin
        lo = seg_break(i);
        hi = seg_break(i + 1);
        if (f >= lo && f < hi) begin
          level = point_level[i]
                  + (longint'(point_level[i+1] - point_level[i]) * (f - lo)) / (hi - lo);
          break;
        end
      end
    end
    return 8'(level);
  endfunction

  function automatic height_req_t random_request();
    height_req_t r;
    int pick;
    int k;
    int v;
    pick = $urandom_range(99);
    k = $urandom_range(POINTS - 1);
    r.action = 1'($urandom_range(1));
    r.raw = 13'($urandom);
    r.frac = 18'($urandom);
    if (pick < 40) begin
      v = point_height[0] - int'(base_cfg) + int'($urandom_range(440)) - 4;
      r.action = 1'b0;
      r.raw = 13'(v);
    end else if (pick < 70) begin
      r.action = 1'b1;
      r.frac = 18'(int'($urandom_range(65540)) - 2);
    end else if (pick < 78) begin
      r.action = 1'b1;
      r.frac = 18'(seg_break(k) + int'($urandom_range(2)) - 1);
    end else if (pick < 86) begin
      v = point_height[k] - int'(base_cfg) + int'($urandom_range(2)) - 1;
      r.action = 1'b0;
      r.raw = 13'(v);
    end
    return r;
  endfunction

  task automatic push_req(input logic action, input int raw, input longint frac);
    height_req_t r;
    r.action = action;
    r.raw = 13'(raw);
    r.frac = 18'(frac);
    height_requests.push_back(r);
  endtask

  task automatic push_random(input int count);
    repeat (count) height_requests.push_back(random_request());
  endtask

  task automatic drain();
    do @(negedge clk);
    while (height_requests.size() != 0 || s_tvalid || expected_levels.size() != 0);
  endtask

  task automatic write_base(input int value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= BASE_W'(value);
    base_cfg = 11'(value);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // The expected level is worked out when the transfer into the block completes.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_levels.push_back(drive_level(s_tuser, s_tdata[12:0], s_tdata[30:13],
                                              base_cfg));
      end
      if (height_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = height_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= next_req.action;
        s_tdata <= IN_TDATA_W'({next_req.frac, next_req.raw});
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_levels.size() == 0) begin
          $error("pump_level: unexpected transfer with value %0d", m_tdata[7:0]);
          failures++;
        end else begin
          level_due = expected_levels.pop_front();
          if (m_tdata[7:0] !== level_due) begin
            $error("pump_level: expected %0d, got %0d", level_due, m_tdata[7:0]);
            failures++;
          end
        end
      end
      if (hold_requests != hold_served || hold_left > 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_base(0);
    push_req(1'b0, -4096, 0);
    push_req(1'b0, 4095, 131071);
    push_req(1'b0, 0, -131072);
    push_req(1'b0, 143, 0);
    push_req(1'b0, 144, 0);
    push_req(1'b0, 145, 0);
    push_req(1'b0, 400, 0);
    push_req(1'b0, 575, 0);
    push_req(1'b0, 576, 0);
    push_req(1'b0, 577, 0);
    push_req(1'b1, 0, -131072);
    push_req(1'b1, -1, 131071);
    push_req(1'b1, 0, -1);
    push_req(1'b1, 0, 0);
    push_req(1'b1, 0, 1);
    push_req(1'b1, 0, 65535);
    push_req(1'b1, 0, 65536);
    push_req(1'b1, 0, 65537);
    push_req(1'b1, 0, seg_break(1) - 1);
    push_req(1'b1, 0, seg_break(1));
    push_req(1'b1, 0, seg_break(7));
    push_req(1'b1, 0, seg_break(12) + 1);
    drain();

    // The receiver holds off at the start of the batch, so the pipeline backs up.
    write_base(-1024);
    hold_requests++;
    push_random(195);
    drain();

    write_base(1023);
    send_idle_pct = 47;
    push_random(100);
    drain();
    push_random(95);
    drain();

    write_base(int'($urandom_range(2047)) - 1024);
    send_idle_pct = 0;
    stall_pct = 47;
    push_random(195);
    drain();

    write_base(int'($urandom_range(2047)) - 1024);
    send_idle_pct = 12;
    stall_pct = 12;
    push_random(195);
    drain();

    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
